### rtl/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, register indexes and alphabet helpers for the Base64 codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_ALPHABET = 2'd1;
    localparam logic [1:0] CFG_PAD_CHAR = 2'd2;

    localparam logic [6:0] PAD_RESET = 7'd61;

    // one queue entry: all result items caused by one accepted input item
    typedef struct packed {
        logic [3:0][7:0] data;    // result bytes, slot 0 first
        logic [1:0]      cnt_m1;  // number of result items minus one
        logic            has;     // out_byte valid (0 for an end marker)
        logic            last;    // entry closes the stream
        logic            err;     // stream error, shown on the final item
    } b64c_entry_t;

    // six-bit value to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v, input logic url);
        logic [7:0] w;
        begin
            w = {2'b00, v};
            if (v < 6'd26)
            begin
                enc_char = 8'd65 + w;
            end
            else if (v < 6'd52)
            begin
                enc_char = 8'd71 + w;           // 'a' - 26
            end
            else if (v < 6'd62)
            begin
                enc_char = w - 8'd4;            // '0' - 52
            end
            else if (v == 6'd62)
            begin
                enc_char = url ? 8'd45 : 8'd43; // '-' or '+'
            end
            else
            begin
                enc_char = url ? 8'd95 : 8'd47; // '_' or '/'
            end
        end
    endfunction

    // alphabet character to six-bit value; anything else maps to zero
    function automatic logic [5:0] dec_value(input logic [7:0] c, input logic url);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'd65 && c <= 8'd90)
            begin
                d = c - 8'd65;
            end
            else if (c >= 8'd97 && c <= 8'd122)
            begin
                d = c - 8'd71;
            end
            else if (c >= 8'd48 && c <= 8'd57)
            begin
                d = c + 8'd4;
            end
            else if (c == (url ? 8'd45 : 8'd43))
            begin
                d = 8'd62;
            end
            else if (c == (url ? 8'd95 : 8'd47))
            begin
                d = 8'd63;
            end
            dec_value = d[5:0];
        end
    endfunction

endpackage

### rtl/b64c_front.sv
// ----------------------------------------------------------------------------
// b64c_front
// Accepts input items, holds configuration and stream state, and turns each
// item that yields output or ends the stream into one entry with all its results.
// ----------------------------------------------------------------------------
module b64c_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [6:0]           cfg_wdata,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    input  logic                 last_in,
    input  logic                 q_full,
    output logic                 push,
    output b64c_pkg::b64c_entry_t push_entry
);
    import b64c_pkg::*;

    logic       mode_reg, mode_next;
    logic       alph_reg, alph_next;
    logic [6:0] pad_reg, pad_next;
    logic [5:0] res_reg, res_next;
    logic [1:0] phase_reg, phase_next;
    logic       pad_seen_reg, pad_seen_next;
    logic       err_reg, err_next;
    logic       any_reg, any_next;

    logic       accept;
    logic       has_pad;
    logic [7:0] pad8;
    logic [5:0] v;
    logic [7:0] d_byte;
    logic       produced;
    b64c_entry_t ent;

    assign accept  = in_valid && !q_full;
    assign has_pad = (pad_reg != 7'd0);
    assign pad8    = {1'b0, pad_reg};
    assign v       = in_byte[7] ? 6'd0 : dec_value(in_byte, alph_reg);

    always_comb
    begin
        mode_next     = mode_reg;
        alph_next     = alph_reg;
        pad_next      = pad_reg;
        res_next      = res_reg;
        phase_next    = phase_reg;
        pad_seen_next = pad_seen_reg;
        err_next      = err_reg;
        any_next      = any_reg;
        ent           = '0;
        push          = 1'b0;
        d_byte        = 8'd0;
        produced      = 1'b0;

        if (accept && mode_reg == 1'b0)
        begin
            push = 1'b1;
            case (phase_reg)
                2'd0:
                begin
                    ent.data[0] = enc_char(in_byte[7:2], alph_reg);
                    res_next    = {4'd0, in_byte[1:0]};
                    phase_next  = 2'd1;
                    if (last_in)
                    begin
                        ent.data[1] = enc_char({in_byte[1:0], 4'd0}, alph_reg);
                        ent.data[2] = pad8;
                        ent.data[3] = pad8;
                        ent.cnt_m1  = has_pad ? 2'd3 : 2'd1;
                    end
                end
                2'd1:
                begin
                    ent.data[0] = enc_char({res_reg[1:0], in_byte[7:4]}, alph_reg);
                    res_next    = {2'd0, in_byte[3:0]};
                    phase_next  = 2'd2;
                    if (last_in)
                    begin
                        ent.data[1] = enc_char({in_byte[3:0], 2'd0}, alph_reg);
                        ent.data[2] = pad8;
                        ent.cnt_m1  = has_pad ? 2'd2 : 2'd1;
                    end
                end
                default:
                begin
                    ent.data[0] = enc_char({res_reg[3:0], in_byte[7:6]}, alph_reg);
                    ent.data[1] = enc_char(in_byte[5:0], alph_reg);
                    ent.cnt_m1  = 2'd1;
                    res_next    = 6'd0;
                    phase_next  = 2'd0;
                end
            endcase
            ent.has  = 1'b1;
            ent.last = last_in;
            any_next = 1'b1;
        end
        else if (accept)
        begin
            if (pad_seen_reg)
            begin
                // drop everything after a pad
            end
            else if (has_pad && in_byte == pad8)
            begin
                pad_seen_next = 1'b1;
            end
            else
            begin
                if (in_byte[7])
                begin
                    err_next = 1'b1;
                end
                case (phase_reg)
                    2'd0:
                    begin
                        res_next   = v;
                        phase_next = 2'd1;
                    end
                    2'd1:
                    begin
                        d_byte     = {res_reg, v[5:4]};
                        res_next   = {2'd0, v[3:0]};
                        phase_next = 2'd2;
                        produced   = 1'b1;
                    end
                    2'd2:
                    begin
                        d_byte     = {res_reg[3:0], v[5:2]};
                        res_next   = {4'd0, v[1:0]};
                        phase_next = 2'd3;
                        produced   = 1'b1;
                    end
                    default:
                    begin
                        d_byte     = {res_reg[1:0], v};
                        res_next   = 6'd0;
                        phase_next = 2'd0;
                        produced   = 1'b1;
                    end
                endcase
                if (produced)
                begin
                    any_next = 1'b1;
                end
            end
            push        = produced || last_in;
            ent.data[0] = d_byte;
            ent.has     = produced;
            ent.last    = last_in;
            // a single dangling character leaves the phase at one
            ent.err     = last_in && (err_next || !any_next || phase_next == 2'd1);
        end

        if (accept && last_in)
        begin
            res_next      = 6'd0;
            phase_next    = 2'd0;
            pad_seen_next = 1'b0;
            err_next      = 1'b0;
            any_next      = 1'b0;
        end

        if (cfg_we && (cfg_addr == CFG_MODE || cfg_addr == CFG_ALPHABET ||
                       cfg_addr == CFG_PAD_CHAR))
        begin
            case (cfg_addr)
                CFG_MODE:     mode_next = cfg_wdata[0];
                CFG_ALPHABET: alph_next = cfg_wdata[0];
                CFG_PAD_CHAR: pad_next  = cfg_wdata;
                default:      pad_next  = pad_reg;
            endcase
            res_next      = 6'd0;
            phase_next    = 2'd0;
            pad_seen_next = 1'b0;
            err_next      = 1'b0;
            any_next      = 1'b0;
        end
    end

    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            alph_reg     <= 1'b0;
            pad_reg      <= PAD_RESET;
            res_reg      <= 6'd0;
            phase_reg    <= 2'd0;
            pad_seen_reg <= 1'b0;
            err_reg      <= 1'b0;
            any_reg      <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            alph_reg     <= alph_next;
            pad_reg      <= pad_next;
            res_reg      <= res_next;
            phase_reg    <= phase_next;
            pad_seen_reg <= pad_seen_next;
            err_reg      <= err_next;
            any_reg      <= any_next;
        end
    end

endmodule

### rtl/b64c_queue.sv
// ----------------------------------------------------------------------------
// b64c_queue
// Short register queue of entries between the front and the back.
// ----------------------------------------------------------------------------
module b64c_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b64c_pkg::b64c_entry_t push_entry,
    input  logic                  pop,
    output b64c_pkg::b64c_entry_t head,
    output logic                  full,
    output logic                  empty
);
    import b64c_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    b64c_entry_t       slots [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/b64c_back.sv
// ----------------------------------------------------------------------------
// b64c_back
// Walks the head entry into the output register, one item per unstalled cycle.
// ----------------------------------------------------------------------------
module b64c_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64c_pkg::b64c_entry_t head,
    input  logic                  q_empty,
    output logic                  pop,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [7:0]            out_byte,
    output logic                  has_data,
    output logic                  out_last,
    output logic                  error
);
    import b64c_pkg::*;

    logic       valid_reg, valid_next;
    logic [1:0] sub_reg, sub_next;
    logic [7:0] byte_reg;
    logic       has_reg, last_reg, err_reg;
    logic       load;
    logic       final_item;

    assign load       = !q_empty && (!valid_reg || !out_stall);
    assign final_item = (sub_reg == head.cnt_m1);
    assign pop        = load && final_item;

    always_comb
    begin
        valid_next = valid_reg;
        sub_next   = sub_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sub_next   = final_item ? 2'd0 : sub_reg + 2'd1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.data[sub_reg];
            has_reg  <= head.has;
            last_reg <= head.last && final_item;
            err_reg  <= head.err && final_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign has_data  = has_reg;
    assign out_last  = last_reg;
    assign error     = err_reg;

endmodule

### rtl/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming Base64 encoder/decoder with selectable alphabet and pad character.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   in_byte, last_in
//  out      output     out_valid / out_stall out_byte, has_data, out_last, error
//  cfg      input      cfg_we                cfg_addr, cfg_wdata
//
//  The front takes one item per cycle while the queue has room. The back
//  sends one result item per cycle from the output register unless out_stall
//  holds it. Encoding yields one or two characters per byte (1.33 on average
//  over a group) and up to four on a final byte; decoding yields at most one
//  byte per character. Reset clears configuration to encode, standard
//  alphabet, pad '=' and empties the queue. A stalled output holds its item
//  while the front keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module base64_stream_codec #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [6:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       last_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       has_data,
    output logic       out_last,
    output logic       error
);
    import b64c_pkg::*;

    b64c_entry_t push_entry;
    b64c_entry_t head;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;

    // stall the input whenever the queue cannot take another entry
    assign in_stall = q_full;

    // front: classify each item and build its entry
    b64c_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_byte    (in_byte),
        .last_in    (last_in),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // queue: decouple the two sides
    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // back: serialize entries into output items
    b64c_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .has_data  (has_data),
        .out_last  (out_last),
        .error     (error)
    );

endmodule
